// ===== rtl/dds_pkg.sv =====
// ----------------------------------------------------------------------------
// dds_pkg
// Shared types, codes, default sizes and the sine table generator for the
// direct digital synthesis tone generator.
// ----------------------------------------------------------------------------
package dds_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DEF_ACC_BITS        = 32;
  localparam int DEF_TABLE_ADDR_BITS = 8;
  localparam int DEF_SAMPLE_BITS     = 8;
  localparam int DEF_OUT_BITS        = 8;

  // Fixed field widths.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int STEP_W     = 32;
  localparam int DUR_W      = 32;
  localparam int DELTA_W    = 32;
  localparam int AMP_W      = 8;
  localparam int LEVEL_W    = 8;

  // Amplitude handling: full scale bypasses the multiply, others shift by eight.
  localparam logic [AMP_W-1:0] FULL_AMP  = 8'd255;
  localparam int               AMP_SHIFT = 8;

  // Item modes.
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_ADD   = 2'd3
  } mode_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_HIGH = 2'd2;

  // Per-beat control that travels down the pipeline with the table index.
  typedef struct packed {
    logic use_sample;  // show the sine sample, else the idle level
    logic active;      // playback running after this beat
  } stage_ctrl_t;

  // Quarter-wave sine magnitude for entry q of a table with 2^addr_bits
  // entries per period. A fixed Q16 odd polynomial approximates sin, which is
  // scaled to the sample peak, rounded half up and clamped.
  function automatic logic [15:0] quarter_sine(input int unsigned q,
                                               input int unsigned addr_bits,
                                               input int unsigned sample_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    longint unsigned peak;
    peak = (64'd1 << (sample_bits - 1)) - 64'd1;
    x    = (64'(q) << 16) >> (addr_bits - 2);
    x2   = (x * x) >> 16;
    t    = (64'd5223 * x2) >> 16;
    t    = 64'd42334 - t;
    t    = (t * x2) >> 16;
    t    = 64'd102944 - t;
    s    = (t * x) >> 16;
    v    = (s * peak + 64'd32768) >> 16;
    if (v > peak) begin
      v = peak;
    end
    return 16'(v);
  endfunction

endpackage

// ===== rtl/dds_ctrl.sv =====
// ----------------------------------------------------------------------------
// dds_ctrl
// Playback state and phase accumulator. Each accepted beat updates the state
// and registers the table index and control for the next stage.
// ----------------------------------------------------------------------------
module dds_ctrl #(
  parameter int ACC_BITS        = dds_pkg::DEF_ACC_BITS,
  parameter int TABLE_ADDR_BITS = dds_pkg::DEF_TABLE_ADDR_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_mode,
  input  logic [dds_pkg::DUR_W-1:0]        in_duration,
  input  logic [dds_pkg::DELTA_W-1:0]      in_phase_delta,
  input  logic [dds_pkg::STEP_W-1:0]       step_rate,
  output logic                             s1_valid,
  input  logic                             s2_load,
  output logic [TABLE_ADDR_BITS-1:0]       s1_index,
  output dds_pkg::stage_ctrl_t             s1_ctrl
);

  localparam logic [dds_pkg::DUR_W-1:0] ONE_TICK = 1;

  logic [ACC_BITS-1:0]           phase_r, phase_nxt, phase_stepped;
  logic [dds_pkg::DUR_W-1:0]     ticks_r, ticks_nxt;
  logic                          playing_r, playing_nxt;
  logic                          limited_r, limited_nxt;
  logic                          use_sample;
  logic                          s1_valid_r;
  logic                          s1_load;
  logic                          accept;
  logic [TABLE_ADDR_BITS-1:0]    index_r;
  dds_pkg::stage_ctrl_t          ctrl_r;

  assign s1_load  = !s1_valid_r || s2_load;
  assign in_ready = s1_load;
  assign accept   = in_valid && s1_load;

  assign phase_stepped = phase_r + step_rate[ACC_BITS-1:0];

  always_comb begin
    phase_nxt   = phase_r;
    ticks_nxt   = ticks_r;
    playing_nxt = playing_r;
    limited_nxt = limited_r;
    use_sample  = 1'b0;
    unique case (dds_pkg::mode_t'(in_mode))
      dds_pkg::MODE_TICK: begin
        if (playing_r) begin
          ticks_nxt = ticks_r - ONE_TICK;
          if (limited_r && (ticks_r == '0)) begin
            // Timed run has expired: stop and rewind the phase.
            playing_nxt = 1'b0;
            phase_nxt   = '0;
          end else begin
            phase_nxt  = phase_stepped;
            use_sample = 1'b1;
          end
        end
      end
      dds_pkg::MODE_START: begin
        ticks_nxt   = in_duration;
        limited_nxt = (in_duration != '0);
        playing_nxt = 1'b1;
        use_sample  = 1'b1;
      end
      dds_pkg::MODE_STOP: begin
        playing_nxt = 1'b0;
      end
      dds_pkg::MODE_ADD: begin
        phase_nxt  = phase_r + in_phase_delta[ACC_BITS-1:0];
        use_sample = playing_r;
      end
      default: begin
        use_sample = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      ticks_r    <= '0;
      playing_r  <= 1'b0;
      limited_r  <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r   <= phase_nxt;
        ticks_r   <= ticks_nxt;
        playing_r <= playing_nxt;
        limited_r <= limited_nxt;
      end
      if (s1_load) begin
        s1_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      index_r           <= phase_nxt[ACC_BITS-1 -: TABLE_ADDR_BITS];
      ctrl_r.use_sample <= use_sample;
      ctrl_r.active     <= playing_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_index = index_r;
  assign s1_ctrl  = ctrl_r;

endmodule

// ===== rtl/dds_rom.sv =====
// ----------------------------------------------------------------------------
// dds_rom
// Quarter-wave sine table with a registered read. The quadrant folds the
// index into the quarter table and selects the sign of the sample.
// ----------------------------------------------------------------------------
module dds_rom #(
  parameter int TABLE_ADDR_BITS = dds_pkg::DEF_TABLE_ADDR_BITS,
  parameter int SAMPLE_BITS     = dds_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s1_valid,
  output logic                          s2_load,
  input  logic [TABLE_ADDR_BITS-1:0]    s1_index,
  input  dds_pkg::stage_ctrl_t          s1_ctrl,
  output logic                          s2_valid,
  input  logic                          s3_load,
  output logic [SAMPLE_BITS-2:0]        s2_mag,
  output logic                          s2_neg,
  output dds_pkg::stage_ctrl_t          s2_ctrl
);

  localparam int QA_BITS = TABLE_ADDR_BITS - 1;
  localparam int QUARTER = 1 << (TABLE_ADDR_BITS - 2);
  localparam int MAG_BITS = SAMPLE_BITS - 1;
  localparam logic [QA_BITS-1:0] QUARTER_A = QA_BITS'(QUARTER);

  logic [MAG_BITS-1:0]          qtab [QUARTER+1];
  logic [1:0]                   quad;
  logic [TABLE_ADDR_BITS-3:0]   qoff;
  logic [QA_BITS-1:0]           addr;
  logic                         s2_valid_r;
  logic [MAG_BITS-1:0]          mag_r;
  logic                         neg_r;
  dds_pkg::stage_ctrl_t         ctrl_r;

  for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_qtab
    assign qtab[gi] = MAG_BITS'(dds_pkg::quarter_sine(gi, TABLE_ADDR_BITS, SAMPLE_BITS));
  end

  assign quad = s1_index[TABLE_ADDR_BITS-1 -: 2];
  assign qoff = s1_index[TABLE_ADDR_BITS-3:0];
  // Odd quadrants run the quarter wave backward.
  assign addr = quad[0] ? (QUARTER_A - {1'b0, qoff}) : {1'b0, qoff};

  assign s2_load = !s2_valid_r || s3_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      mag_r  <= qtab[addr];
      neg_r  <= quad[1];
      ctrl_r <= s1_ctrl;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_mag   = mag_r;
  assign s2_neg   = neg_r;
  assign s2_ctrl  = ctrl_r;

endmodule

// ===== rtl/dds_scale.sv =====
// ----------------------------------------------------------------------------
// dds_scale
// Amplitude scaling, output width alignment and mid-scale offset, feeding the
// output register of the result channel.
// ----------------------------------------------------------------------------
module dds_scale #(
  parameter int SAMPLE_BITS = dds_pkg::DEF_SAMPLE_BITS,
  parameter int OUT_BITS    = dds_pkg::DEF_OUT_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            s2_valid,
  output logic                            s3_load,
  input  logic [SAMPLE_BITS-2:0]          s2_mag,
  input  logic                            s2_neg,
  input  dds_pkg::stage_ctrl_t            s2_ctrl,
  input  logic [dds_pkg::AMP_W-1:0]       amplitude,
  input  logic                            idle_high,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dds_pkg::LEVEL_W-1:0]     out_level,
  output logic                            out_active
);

  localparam int W  = SAMPLE_BITS + 11;
  localparam int UP = (OUT_BITS > SAMPLE_BITS) ? (OUT_BITS - SAMPLE_BITS) : 0;
  localparam int DN = (SAMPLE_BITS > OUT_BITS) ? (SAMPLE_BITS - OUT_BITS) : 0;
  localparam logic signed [W-1:0] MID_W = W'(1 << (OUT_BITS - 1));

  logic signed [W-1:0]             samp_w, amp_w, prod_w, scaled_w, aligned_w, sum_w;
  logic [dds_pkg::LEVEL_W-1:0]     level_nxt;
  logic                            out_valid_r;
  logic [dds_pkg::LEVEL_W-1:0]     level_r;
  logic                            active_r;

  always_comb begin
    samp_w = W'({1'b0, s2_mag});
    if (s2_neg) begin
      samp_w = -samp_w;
    end
    amp_w  = W'({1'b0, amplitude});
    prod_w = samp_w * amp_w;
    // Arithmetic shift gives the floor of the scaled product.
    scaled_w  = (amplitude == dds_pkg::FULL_AMP) ? samp_w : (prod_w >>> dds_pkg::AMP_SHIFT);
    aligned_w = (scaled_w <<< UP) >>> DN;
    sum_w     = aligned_w + MID_W;
    if (!s2_ctrl.use_sample) begin
      level_nxt = idle_high ? MID_W[dds_pkg::LEVEL_W-1:0] : '0;
    end else if (amplitude == '0) begin
      level_nxt = MID_W[dds_pkg::LEVEL_W-1:0];
    end else begin
      level_nxt = sum_w[dds_pkg::LEVEL_W-1:0];
    end
  end

  assign s3_load = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_load) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load && s2_valid) begin
      level_r  <= level_nxt;
      active_r <= s2_ctrl.active;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_level  = level_r;
  assign out_active = active_r;

endmodule

// ===== rtl/dds_sine_tone_generator_core.sv =====
// ----------------------------------------------------------------------------
// dds_sine_tone_generator_core
// Direct digital synthesis tone generator with timed playback.
// ----------------------------------------------------------------------------
// The generator takes one beat per clock cycle while the result side is ready
// and returns exactly one result beat for each. The result moves through the
// stage one, table and output registers and is held on out_valid until out_ready
// takes it. The phase accumulator and the playback state are updated in the
// cycle a beat is accepted, so that single add and compare loop sets the
// rate; the sine table read and the amplitude multiply follow in their own
// registered stages. Every stage has its own valid bit, so empty stages keep
// filling while a finished result waits for out_ready. Configuration writes
// take effect at once and are meant to be made while no beats are in flight.
module dds_sine_tone_generator_core #(
  parameter int ACC_BITS        = dds_pkg::DEF_ACC_BITS,
  parameter int TABLE_ADDR_BITS = dds_pkg::DEF_TABLE_ADDR_BITS,
  parameter int SAMPLE_BITS     = dds_pkg::DEF_SAMPLE_BITS,
  parameter int OUT_BITS        = dds_pkg::DEF_OUT_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port.
  input  logic                                cfg_wr_en,
  input  logic [dds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dds_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // Input channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_mode,
  input  logic [dds_pkg::DUR_W-1:0]           in_duration,
  input  logic [dds_pkg::DELTA_W-1:0]         in_phase_delta,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dds_pkg::LEVEL_W-1:0]         out_level,
  output logic                                out_active
);

  logic [dds_pkg::STEP_W-1:0]    step_rate_r;
  logic [dds_pkg::AMP_W-1:0]     amplitude_r;
  logic                          idle_high_r;

  logic                          s1_valid, s2_load, s2_valid, s3_load;
  logic [TABLE_ADDR_BITS-1:0]    s1_index;
  dds_pkg::stage_ctrl_t          s1_ctrl, s2_ctrl;
  logic [SAMPLE_BITS-2:0]        s2_mag;
  logic                          s2_neg;

  // Configuration registers. Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_rate_r <= '0;
      amplitude_r <= dds_pkg::FULL_AMP;
      idle_high_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dds_pkg::REG_STEP_RATE: step_rate_r <= cfg_wdata[dds_pkg::STEP_W-1:0];
        dds_pkg::REG_AMPLITUDE: amplitude_r <= cfg_wdata[dds_pkg::AMP_W-1:0];
        dds_pkg::REG_IDLE_HIGH: idle_high_r <= cfg_wdata[0];
        default: begin
          step_rate_r <= step_rate_r;
        end
      endcase
    end
  end

  // Stage one: playback state, phase accumulator and table index.
  dds_ctrl #(
    .ACC_BITS        (ACC_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_duration    (in_duration),
    .in_phase_delta (in_phase_delta),
    .step_rate      (step_rate_r),
    .s1_valid       (s1_valid),
    .s2_load        (s2_load),
    .s1_index       (s1_index),
    .s1_ctrl        (s1_ctrl)
  );

  // Stage two: quarter-wave table read.
  dds_rom #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_rom (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s2_load  (s2_load),
    .s1_index (s1_index),
    .s1_ctrl  (s1_ctrl),
    .s2_valid (s2_valid),
    .s3_load  (s3_load),
    .s2_mag   (s2_mag),
    .s2_neg   (s2_neg),
    .s2_ctrl  (s2_ctrl)
  );

  // Stage three: gain, offset and the output register.
  dds_scale #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .OUT_BITS    (OUT_BITS)
  ) u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .s2_valid   (s2_valid),
    .s3_load    (s3_load),
    .s2_mag     (s2_mag),
    .s2_neg     (s2_neg),
    .s2_ctrl    (s2_ctrl),
    .amplitude  (amplitude_r),
    .idle_high  (idle_high_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_level  (out_level),
    .out_active (out_active)
  );

`ifndef SYNTH
  // A ready result side always lets a new beat in.
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // A stop beat always leaves playback inactive.
  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_mode == dds_pkg::MODE_STOP))
      |=> (s1_valid && !s1_ctrl.active && !s1_ctrl.use_sample))
    else $error("stop beat did not clear playback");

  // A start beat always plays the sample at the current phase.
  a_start_plays: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_mode == dds_pkg::MODE_START))
      |=> (s1_valid && s1_ctrl.active && s1_ctrl.use_sample))
    else $error("start beat did not begin playback");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !s1_valid && !s2_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

// ===== test/dds_sine_tone_generator_core_tb.sv =====
// ----------------------------------------------------------------------------
// dds_sine_tone_generator_core_tb
// Self-checking bench for the sine tone generator. Every accepted input beat
// runs through a local model of the phase accumulator, the playback timer
// and the scaled sine lookup. The model's level and active flag are queued
// and compared with each result beat in order. Directed beats cover the
// corner cases first. Segments of random playback traffic follow, each under
// its own register setting, mostly with random stalls on both channels.
// ----------------------------------------------------------------------------
module dds_sine_tone_generator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Sizes of the default build; the local model follows them.
  localparam int PHASE_W    = dds_pkg::DEF_ACC_BITS;
  localparam int INDEX_W    = dds_pkg::DEF_TABLE_ADDR_BITS;
  localparam int PEAK       = (1 << (dds_pkg::DEF_SAMPLE_BITS - 1)) - 1;
  localparam int MID_LEVEL  = 1 << (dds_pkg::DEF_OUT_BITS - 1);
  localparam int QUARTER    = 1 << (INDEX_W - 2);
  // The index port reaches one code past the last register. The block must
  // ignore writes to it.
  localparam logic [dds_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int SEGMENTS     = 10;
  localparam int SEGMENT_BEATS = 85;
  localparam int MAX_WAIT     = 12;
  // A healthy run finishes far sooner than this.
  localparam longint RUN_LIMIT_NS = 64'd5_000_000;

  // Level and active flag of one result beat.
  typedef struct packed {
    logic [dds_pkg::LEVEL_W-1:0] level;
    logic                        active;
  } tone_beat_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_wr_en;
  logic [dds_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dds_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_ready;
  logic [1:0]                     in_mode;
  logic [dds_pkg::DUR_W-1:0]      in_duration;
  logic [dds_pkg::DELTA_W-1:0]    in_phase_delta;
  logic                           out_valid;
  logic                           out_ready;
  logic [dds_pkg::LEVEL_W-1:0]    out_level;
  logic                           out_active;

  dds_sine_tone_generator_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_duration    (in_duration),
    .in_phase_delta (in_phase_delta),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_level      (out_level),
    .out_active     (out_active)
  );

  // Model copy of the registers.
  logic [dds_pkg::STEP_W-1:0] tone_step;
  logic [dds_pkg::AMP_W-1:0]  tone_gain;
  logic                       tone_idle_high;

  // Model copy of the generator state.
  logic [PHASE_W-1:0]         tone_phase;
  logic [dds_pkg::DUR_W-1:0]  tone_ticks;
  logic                       tone_playing;
  logic                       tone_limited;

  // Results the model has produced that the block has not yet returned.
  tone_beat_t tone_due[$];

  // Channel pacing. When a flag is clear, that side never idles.
  bit sender_idles;
  bit receiver_idles;

  int error_count;
  int results_checked;
  int beats_sent;
  int tick_count;
  int start_count;
  int stop_count;
  int add_count;
  int expiry_count;
  int setting_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A generous limit on the whole run. Nothing after this point runs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Timed out with %0d results still pending.", tone_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Local model
  // --------------------------------------------------------------------------

  // Magnitude of a quarter-wave entry. It uses the same fixed Q16 odd
  // polynomial as the table in the block, scaled to the sample peak and
  // rounded half up.
  function automatic int quarter_magnitude(input int unsigned q);
    longint unsigned x;
    longint unsigned xsq;
    longint unsigned acc;
    longint unsigned mag;
    x   = (longint'(q) << 16) >> (INDEX_W - 2);
    xsq = (x * x) >> 16;
    acc = (64'd5223 * xsq) >> 16;
    acc = 64'd42334 - acc;
    acc = (acc * xsq) >> 16;
    acc = 64'd102944 - acc;
    acc = (acc * x) >> 16;
    mag = (acc * longint'(PEAK) + 64'd32768) >> 16;
    if (mag > longint'(PEAK)) begin
      mag = longint'(PEAK);
    end
    return int'(mag);
  endfunction

  // Signed sine sample for a table index, built by quarter-wave symmetry.
  function automatic int sine_sample(input logic [INDEX_W-1:0] idx);
    logic [1:0]  quadrant;
    int unsigned q;
    int          mag;
    quadrant = idx[INDEX_W-1 -: 2];
    q        = int'(idx[INDEX_W-3:0]);
    mag      = quadrant[0] ? quarter_magnitude(QUARTER - q) : quarter_magnitude(q);
    return quadrant[1] ? -mag : mag;
  endfunction

  function automatic logic [dds_pkg::LEVEL_W-1:0] idle_level();
    return tone_idle_high ? dds_pkg::LEVEL_W'(MID_LEVEL) : '0;
  endfunction

  // Output level for the current phase: gain zero pins mid-scale, full gain
  // skips the multiply, any other gain is a floor shift by eight.
  function automatic logic [dds_pkg::LEVEL_W-1:0] tone_level();
    int s;
    if (tone_gain == '0) begin
      return dds_pkg::LEVEL_W'(MID_LEVEL);
    end
    s = sine_sample(tone_phase[PHASE_W-1 -: INDEX_W]);
    if (tone_gain != dds_pkg::FULL_AMP) begin
      s = (s * int'(tone_gain)) >>> dds_pkg::AMP_SHIFT;
    end
    return dds_pkg::LEVEL_W'(s + MID_LEVEL);
  endfunction

  // Moves the model by one input beat and returns the result it calls for.
  function automatic tone_beat_t advance_tone(input dds_pkg::mode_t mode,
                                              input logic [dds_pkg::DUR_W-1:0] dur,
                                              input logic [dds_pkg::DELTA_W-1:0] delta);
    tone_beat_t b;
    case (mode)
      dds_pkg::MODE_TICK: begin
        tick_count++;
        if (tone_playing) begin
          tone_phase = tone_phase + PHASE_W'(tone_step);
          if (tone_limited && tone_ticks == '0) begin
            // The timed run has used up its count: stop and rewind.
            b.level      = idle_level();
            tone_playing = 1'b0;
            tone_phase   = '0;
            expiry_count++;
          end else begin
            b.level = tone_level();
          end
          // Every running tick counts down, wrapping past zero.
          tone_ticks = tone_ticks - 32'd1;
        end else begin
          b.level = idle_level();
        end
      end
      dds_pkg::MODE_START: begin
        start_count++;
        tone_ticks   = dur;
        tone_limited = (dur != '0);
        tone_playing = 1'b1;
      end
      dds_pkg::MODE_STOP: begin
        stop_count++;
        tone_playing = 1'b0;
      end
      default: begin
        add_count++;
        tone_phase = tone_phase + PHASE_W'(delta);
      end
    endcase
    if (mode != dds_pkg::MODE_TICK) begin
      b.level = tone_playing ? tone_level() : idle_level();
    end
    b.active = tone_playing;
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers and result checking
  // --------------------------------------------------------------------------

  task automatic report(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic int draw_wait(input bit idles);
    return idles ? int'($urandom_range(0, MAX_WAIT)) : 0;
  endfunction

  // Sends one beat. The task is entered at a rising edge and returns at the
  // edge where the beat was accepted, with in_valid still high so that a
  // back-to-back beat needs no second assignment in that step.
  task automatic send_beat(input dds_pkg::mode_t mode,
                           input logic [dds_pkg::DUR_W-1:0] dur,
                           input logic [dds_pkg::DELTA_W-1:0] delta);
    int gap;
    gap = draw_wait(sender_idles);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_duration    <= dur;
    in_phase_delta <= delta;
    do @(posedge clk); while (!in_ready);
    tone_due.push_back(advance_tone(mode, dur, delta));
    beats_sent++;
  endtask

  // Holds the sender back until every pending result is in, then lets the
  // pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (tone_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Writes all three registers while the block is idle. With poke_unused
  // set, a junk write to the spare index goes first and must change nothing.
  task automatic set_registers(input logic [dds_pkg::STEP_W-1:0] step,
                               input logic [dds_pkg::AMP_W-1:0] gain,
                               input logic idle_hi, input bit poke_unused);
    drain();
    if (poke_unused) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_UNUSED;
      cfg_wdata <= $urandom;
      @(posedge clk);
    end
    cfg_wr_en <= 1'b1;
    cfg_index <= dds_pkg::REG_STEP_RATE;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_index <= dds_pkg::REG_AMPLITUDE;
    cfg_wdata <= dds_pkg::CFG_DATA_W'(gain);
    @(posedge clk);
    cfg_index <= dds_pkg::REG_IDLE_HIGH;
    cfg_wdata <= dds_pkg::CFG_DATA_W'(idle_hi);
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    tone_step      = step;
    tone_gain      = gain;
    tone_idle_high = idle_hi;
    setting_count++;
  endtask

  // Result side: stalls at random per beat and checks every accepted beat
  // against the oldest pending model result.
  initial begin
    tone_beat_t want;
    int         stall;
    out_ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = draw_wait(receiver_idles);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (tone_due.size() == 0) begin
        report($sformatf("unexpected result beat level %0d active %0b",
                         out_level, out_active));
      end else begin
        want = tone_due.pop_front();
        results_checked++;
        if (out_level !== want.level) begin
          report($sformatf("level %0d, model says %0d (result %0d)",
                           out_level, want.level, results_checked));
        end
        if (out_active !== want.active) begin
          report($sformatf("active %0b, model says %0b (result %0d)",
                           out_active, want.active, results_checked));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: step zero, full gain, idle at zero. Checks the idle
  // output, an unlimited start, phase adds both while stopped and while
  // running, and phase deltas of zero, one, a quarter turn and all ones.
  task automatic test_idle_and_unlimited();
    send_beat(dds_pkg::MODE_TICK, '1, '1);
    send_beat(dds_pkg::MODE_STOP, '0, '0);
    send_beat(dds_pkg::MODE_ADD, '0, 32'hFFFF_FFFF);
    send_beat(dds_pkg::MODE_START, '0, '0);
    send_beat(dds_pkg::MODE_ADD, '0, 32'h0000_0001);
    send_beat(dds_pkg::MODE_TICK, '0, '0);
    send_beat(dds_pkg::MODE_ADD, '0, 32'h4000_0000);
    send_beat(dds_pkg::MODE_ADD, '0, '0);
    send_beat(dds_pkg::MODE_STOP, '1, '1);
  endtask

  // One table entry per tick with the idle level at mid-scale. A timed run
  // of two ticks ends on the third, clears the phase and wraps the count. A
  // restart keeps the phase, and the longest duration is taken once.
  task automatic test_timed_playback();
    set_registers(32'h0100_0000, dds_pkg::FULL_AMP, 1'b1, 1'b1);
    send_beat(dds_pkg::MODE_START, 32'd2, '0);
    send_beat(dds_pkg::MODE_TICK, '0, '0);
    send_beat(dds_pkg::MODE_TICK, '0, '0);
    send_beat(dds_pkg::MODE_TICK, '0, '0);
    send_beat(dds_pkg::MODE_TICK, '0, '0);
    send_beat(dds_pkg::MODE_ADD, '0, 32'h8000_0000);
    send_beat(dds_pkg::MODE_START, 32'hFFFF_FFFF, '0);
    send_beat(dds_pkg::MODE_TICK, '0, '0);
    send_beat(dds_pkg::MODE_STOP, '0, '0);
  endtask

  // Gain corners: zero pins mid-scale, and small and near-full gains round
  // negative samples toward minus infinity. The largest step rate wraps the
  // phase backward by one each tick.
  task automatic test_gain_corners();
    set_registers(32'hFFFF_FFFF, '0, 1'b0, 1'b0);
    send_beat(dds_pkg::MODE_START, '0, '0);
    send_beat(dds_pkg::MODE_TICK, '0, '0);
    set_registers(32'hC000_0000, 8'd1, 1'b0, 1'b0);
    send_beat(dds_pkg::MODE_TICK, '0, '0);
    send_beat(dds_pkg::MODE_ADD, '0, 32'h4000_0000);
    set_registers(32'h0400_0000, 8'd254, 1'b1, 1'b0);
    send_beat(dds_pkg::MODE_TICK, '0, '0);
    send_beat(dds_pkg::MODE_TICK, '0, '0);
  endtask

  function automatic logic [dds_pkg::DUR_W-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return '0;
    end else if (r < 8) begin
      return dds_pkg::DUR_W'($urandom_range(1, 24));
    end
    return $urandom;
  endfunction

  // A start followed by a run of ticks sized to let timed runs expire, with
  // the odd phase add or early stop thrown in.
  task automatic play_run();
    logic [dds_pkg::DUR_W-1:0] dur;
    int                        run_len;
    int                        r;
    dur = pick_duration();
    send_beat(dds_pkg::MODE_START, dur, $urandom);
    if (dur != '0 && dur < 30) begin
      run_len = int'(dur) + $urandom_range(0, 3);
    end else begin
      run_len = $urandom_range(1, 30);
    end
    repeat (run_len) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        send_beat(dds_pkg::MODE_STOP, $urandom, $urandom);
      end else if (r < 3) begin
        send_beat(dds_pkg::MODE_ADD, $urandom, $urandom);
      end else begin
        send_beat(dds_pkg::MODE_TICK, $urandom, $urandom);
      end
    end
  endtask

  function automatic logic [dds_pkg::STEP_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 32'h0100_0000;
      3: return $urandom >> 4;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [dds_pkg::AMP_W-1:0] pick_gain();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 8'd1;
      2: return 8'd128;
      3: return 8'd254;
      4: return dds_pkg::FULL_AMP;
      default: return dds_pkg::AMP_W'($urandom);
    endcase
  endfunction

  // Mostly well-formed playback runs with random content; the rest is loose
  // beats of any mode. Each segment gets fresh registers and pacing, one
  // segment runs with no stalls at all, and now and then the sender waits
  // for the pipeline to empty.
  task automatic test_random_traffic();
    int seg_start;
    int r;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0:       set_registers('1, pick_gain(), 1'b0, 1'b1);
        1:       set_registers(pick_step(), '0, 1'b1, 1'b0);
        2:       set_registers(pick_step(), dds_pkg::FULL_AMP, 1'b1, 1'b0);
        default: set_registers(pick_step(), pick_gain(), 1'($urandom), seg[0]);
      endcase
      sender_idles   = (seg == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
      receiver_idles = (seg == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
      seg_start = beats_sent;
      while (beats_sent - seg_start < SEGMENT_BEATS) begin
        r = $urandom_range(0, 19);
        if (r < 12) begin
          play_run();
        end else if (r < 19) begin
          send_beat(dds_pkg::mode_t'($urandom_range(0, 3)), $urandom, $urandom);
        end else begin
          drain();
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_mode        = '0;
    in_duration    = '0;
    in_phase_delta = '0;

    // Register and state values the block comes out of reset with.
    tone_step      = '0;
    tone_gain      = dds_pkg::FULL_AMP;
    tone_idle_high = 1'b0;
    tone_phase     = '0;
    tone_ticks     = '0;
    tone_playing   = 1'b0;
    tone_limited   = 1'b0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_and_unlimited();
    test_timed_playback();
    test_gain_corners();
    test_random_traffic();

    drain();
    $display("Sent %0d beats: %0d ticks, %0d starts, %0d stops, %0d phase adds.",
             beats_sent, tick_count, start_count, stop_count, add_count);
    $display("%0d register settings, %0d timed runs expired, %0d results checked.",
             setting_count, expiry_count, results_checked);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches.", error_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
